FILE: rtl/half_float_hdr_tone_map_to_srgb8_top_assert.svh
// Assertion macros for the tone mapper checker.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef HALF_FLOAT_HDR_TONE_MAP_TO_SRGB8_TOP_ASSERT_SVH
`define HALF_FLOAT_HDR_TONE_MAP_TO_SRGB8_TOP_ASSERT_SVH

// same-cycle implication
`define HFTM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hftm checker: implication failed");

// next-cycle implication
`define HFTM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hftm checker: next-cycle implication failed");

`endif

FILE: rtl/hftm_pkg.sv
// Shared types, constants and the threshold table of the tone mapper.
// No dependencies; the table is built at elaboration from exact integer tests.
package hftm_pkg;

	localparam int unsigned HALF_W     = 16;
	localparam int unsigned POS_W      = 15;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned NUM_STEPS  = 8;
	localparam int unsigned NUM_STAGES = NUM_STEPS + 1;
	localparam int unsigned NUM_CODES  = 256;
	localparam int unsigned N_W        = 41;
	localparam int unsigned BIG_W      = 448;

	localparam int unsigned LIN_SCALE  = 32946;
	localparam int unsigned LIN_LAST   = 10;
	localparam int unsigned LIN_MUL    = 10;
	localparam int unsigned POW_DEN    = 10761;
	localparam int unsigned POW_OFS    = 561;
	localparam int unsigned POW_MUL    = 40;
	localparam int unsigned ONE_SHIFT  = 24;
	localparam int unsigned POW_NUM    = 5;
	localparam int unsigned POW_ROOT   = 12;

	localparam logic [4:0]       EXP_MAX   = 5'h1F;
	localparam logic [4:0]       EXP_ZERO  = 5'h00;
	localparam logic [9:0]       MAN_HID   = 10'h000;
	localparam logic [POS_W-1:0] POS_INF   = 15'h7C00;
	localparam logic [POS_W-1:0] POS_TOP   = 15'h7FFF;
	localparam logic [BYTE_W-1:0] BYTE_FULL = 8'hFF;
	localparam int unsigned      CODE_TOP  = 255;

	typedef logic [NUM_CODES-1:0][POS_W-1:0] thr_table_t;

	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
	} hftm_ctl_t;

	function automatic logic [N_W-1:0] half_to_n(input logic [POS_W-1:0] p);
		logic [4:0]     ex;
		logic [N_W-1:0] m;
		ex = p[14:10];
		m  = N_W'(p[9:0]);
		if (ex == EXP_ZERO)
			return m;
		return (m | N_W'(11'h400)) << (ex - 5'd1);
	endfunction

	function automatic logic reaches(input logic [N_W-1:0] n, input int unsigned k);
		logic [N_W-1:0]   d;
		logic [BIG_W-1:0] lhs;
		logic [BIG_W-1:0] rhs;
		logic [63:0]      lin_l;
		logic [63:0]      lin_r;
		int               i;
		d = n + (N_W'(1) << ONE_SHIFT);
		if (k == 0)
			return 1'b1;
		if (k <= LIN_LAST) begin
			lin_l = 64'(LIN_SCALE) * 64'(n);
			lin_r = 64'(LIN_MUL * k) * 64'(d);
			return lin_l >= lin_r;
		end
		lhs = BIG_W'(1);
		rhs = BIG_W'(1);
		for (i = 0; i < POW_NUM; i++) begin
			lhs = lhs * BIG_W'(n);
			rhs = rhs * BIG_W'(d);
		end
		for (i = 0; i < POW_ROOT; i++) begin
			lhs = lhs * BIG_W'(POW_DEN);
			rhs = rhs * BIG_W'(POW_MUL * k + POW_OFS);
		end
		return lhs >= rhs;
	endfunction

	// smallest pattern whose byte reaches k, the infinity pattern when none; 0 for k = 0, the top pattern for k = 255
	function automatic logic [POS_W-1:0] thr_of(input int unsigned k);
		logic [POS_W:0] lo;
		logic [POS_W:0] hi;
		logic [POS_W:0] mid;
		if (k == 0)
			return '0;
		if (k == CODE_TOP)
			return POS_TOP;
		lo = '0;
		hi = {1'b0, POS_INF};
		while (lo < hi) begin
			mid = (lo + hi) >> 1;
			if (reaches(half_to_n(mid[POS_W-1:0]), k))
				hi = mid;
			else
				lo = mid + 1'b1;
		end
		return lo[POS_W-1:0];
	endfunction

	function automatic thr_table_t build_thr();
		thr_table_t t;
		for (int k = 0; k < NUM_CODES; k++)
			t[k] = thr_of(k);
		return t;
	endfunction

	localparam thr_table_t THR = build_thr();

endpackage

FILE: rtl/hftm_if.sv
// Pixel and result channel interfaces: valid, ready and payload.
// Depends on hftm_pkg for field widths.
interface hftm_in_if;
	import hftm_pkg::*;
	logic              valid;
	logic              ready;
	logic [HALF_W-1:0] red_half;
	logic [HALF_W-1:0] green_half;
	logic [HALF_W-1:0] blue_half;
	modport source (output valid, output red_half, output green_half, output blue_half,
		input ready);
	modport sink (input valid, input red_half, input green_half, input blue_half,
		output ready);
endinterface

interface hftm_out_if;
	import hftm_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] blue_out;
	logic [BYTE_W-1:0] green_out;
	logic [BYTE_W-1:0] red_out;
	modport source (output valid, output blue_out, output green_out, output red_out,
		input ready);
	modport sink (input valid, input blue_out, input green_out, input red_out,
		output ready);
endinterface

FILE: rtl/hftm_lane.sv
// One channel lane: special-case filter and an eight-step threshold search.
// Depends on hftm_pkg for the threshold table and stage enables.
module hftm_lane (
	input  logic                      clk,
	input  hftm_pkg::hftm_ctl_t       ctl,
	input  logic [hftm_pkg::HALF_W-1:0] half_in,
	output logic [hftm_pkg::BYTE_W-1:0] byte_out
);
	import hftm_pkg::*;

	logic [POS_W-1:0]  pos_s  [NUM_STAGES];
	logic [BYTE_W-1:0] code_s [NUM_STAGES];
	logic              full_s [NUM_STAGES];

	logic             is_nan;
	logic             kill;
	logic [POS_W-1:0] pos_in;
	logic             full_in;

	always_comb begin
		is_nan  = (half_in[14:10] == EXP_MAX) && (half_in[9:0] != MAN_HID);
		kill    = half_in[15] || is_nan;
		pos_in  = kill ? '0 : half_in[POS_W-1:0];
		full_in = !half_in[15] && (half_in[POS_W-1:0] == POS_INF);
	end

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			pos_s[0]  <= pos_in;
			code_s[0] <= '0;
			full_s[0] <= full_in;
		end
	end

	for (genvar j = 0; j < NUM_STEPS; j++) begin : g_step
		logic [BYTE_W-1:0] cand;
		logic              hit;

		always_comb begin
			cand = code_s[j] | BYTE_W'(1 << (NUM_STEPS - 1 - j));
			hit  = pos_s[j] >= THR[cand];
		end

		always_ff @(posedge clk) begin
			if (ctl.en[j+1]) begin
				pos_s[j+1]  <= pos_s[j];
				code_s[j+1] <= hit ? cand : code_s[j];
				full_s[j+1] <= full_s[j];
			end
		end
	end

	assign byte_out = full_s[NUM_STAGES-1] ? BYTE_FULL : code_s[NUM_STAGES-1];

endmodule

FILE: rtl/hftm_merge.sv
// Stage valids, advance chain and the output register that joins the lanes.
// Depends on hftm_pkg for stage count and the enable struct.
module hftm_merge (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	output hftm_pkg::hftm_ctl_t         ctl,
	input  logic [hftm_pkg::BYTE_W-1:0] red_code,
	input  logic [hftm_pkg::BYTE_W-1:0] green_code,
	input  logic [hftm_pkg::BYTE_W-1:0] blue_code,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [hftm_pkg::BYTE_W-1:0] blue_out,
	output logic [hftm_pkg::BYTE_W-1:0] green_out,
	output logic [hftm_pkg::BYTE_W-1:0] red_out
);
	import hftm_pkg::*;

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES:0]   adv;
	logic                  out_vld_q;
	logic [BYTE_W-1:0]     blue_q;
	logic [BYTE_W-1:0]     green_q;
	logic [BYTE_W-1:0]     red_q;

	// a stage takes a new beat when it is empty or its own beat moves on
	always_comb begin
		adv[NUM_STAGES] = !out_vld_q || out_ready;
		for (int i = NUM_STAGES - 1; i >= 0; i--)
			adv[i] = !vld_q[i] || adv[i+1];
	end

	assign ctl.en   = adv[NUM_STAGES-1:0];
	assign in_ready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (adv[0])
				vld_q[0] <= in_valid;
			for (int i = 1; i < NUM_STAGES; i++)
				if (adv[i])
					vld_q[i] <= vld_q[i-1];
			if (adv[NUM_STAGES])
				out_vld_q <= vld_q[NUM_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NUM_STAGES]) begin
			blue_q  <= blue_code;
			green_q <= green_code;
			red_q   <= red_code;
		end
	end

	assign out_valid = out_vld_q;
	assign blue_out  = blue_q;
	assign green_out = green_q;
	assign red_out   = red_q;

endmodule

FILE: rtl/half_float_hdr_tone_map_to_srgb8_top.sv
// Reinhard tone mapper from half-float RGB to sRGB BGR bytes, one pixel per clock.
// Depends on hftm_pkg, hftm_if, hftm_lane and hftm_merge.
//
// Accepts one pixel per clock while the output is not held back, and returns one
// BGR byte triple per pixel, in order. An accepted input beat passes a register
// after the special-case filter, eight per-channel threshold search stages (one
// result bit a stage, each stage one lookup in the 256-entry threshold table and
// one 15-bit compare) and the output register that joins the lanes.
// Each stage holds while the one after it is full and stalled, so bubbles close
// up and input is taken as long as the pipeline has a free stage. Negative values
// and NaN give 0, plus infinity gives 255. No state beyond the pipeline.
module half_float_hdr_tone_map_to_srgb8_top (
	input  logic       clk,
	input  logic       arst_n,
	hftm_in_if.sink    pix_in,
	hftm_out_if.source pix_out
);
	import hftm_pkg::*;

	hftm_ctl_t         ctl;
	logic [BYTE_W-1:0] red_code;
	logic [BYTE_W-1:0] green_code;
	logic [BYTE_W-1:0] blue_code;

	hftm_lane u_lane_red (
		.clk      (clk),
		.ctl      (ctl),
		.half_in  (pix_in.red_half),
		.byte_out (red_code)
	);

	hftm_lane u_lane_green (
		.clk      (clk),
		.ctl      (ctl),
		.half_in  (pix_in.green_half),
		.byte_out (green_code)
	);

	hftm_lane u_lane_blue (
		.clk      (clk),
		.ctl      (ctl),
		.half_in  (pix_in.blue_half),
		.byte_out (blue_code)
	);

	hftm_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (pix_in.valid),
		.in_ready   (pix_in.ready),
		.ctl        (ctl),
		.red_code   (red_code),
		.green_code (green_code),
		.blue_code  (blue_code),
		.out_valid  (pix_out.valid),
		.out_ready  (pix_out.ready),
		.blue_out   (pix_out.blue_out),
		.green_out  (pix_out.green_out),
		.red_out    (pix_out.red_out)
	);

endmodule

FILE: rtl/hftm_checker.sv
// Port-level checker for the tone mapper and its bind to the top level.
// Depends on the assertion macro header and hftm_pkg.
`include "half_float_hdr_tone_map_to_srgb8_top_assert.svh"

module hftm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [hftm_pkg::BYTE_W-1:0] blue_out,
	input logic [hftm_pkg::BYTE_W-1:0] green_out,
	input logic [hftm_pkg::BYTE_W-1:0] red_out
);
	import hftm_pkg::*;

	// input may only be refused while a finished result is held back
	`HFTM_ASSERT_IMP(a_stall_cause, in_valid && !in_ready, out_valid && !out_ready)
	// a result that is held back stays offered
	`HFTM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	// and keeps its bytes
	`HFTM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable({blue_out, green_out, red_out}))
	// with the output free, the pipeline always takes a beat
	`HFTM_ASSERT_IMP(a_free_accept, !out_valid, in_ready)

endmodule

bind half_float_hdr_tone_map_to_srgb8_top hftm_checker u_hftm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix_in.valid),
	.in_ready  (pix_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.blue_out  (pix_out.blue_out),
	.green_out (pix_out.green_out),
	.red_out   (pix_out.red_out)
);
